// ===== src/b64enc_pkg.sv =====
// Shared types, constants and the Base64 alphabet function for the Base64 stream encoder.
package b64enc_pkg;

	localparam int unsigned CHAR_W = 7;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SIX_W = 6;
	localparam int unsigned CARRY_W = 4;
	localparam int unsigned GROUP_CHARS = 4;
	localparam int unsigned IDX_W = $clog2(GROUP_CHARS);

	// Depth of the queue between the front and the back.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	// Position of the next byte inside its three-byte group.
	typedef logic [1:0] pos_t;
	localparam pos_t POS_FIRST = 2'd0;
	localparam pos_t POS_SECOND = 2'd1;
	localparam pos_t POS_THIRD = 2'd2;

	localparam logic [CHAR_W-1:0] PAD_CODE = 7'd61;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_PLUS = 7'd43;
	localparam logic [CHAR_W-1:0] ASCII_SLASH = 7'd47;

	typedef logic [CHAR_W-1:0] char_t;

	// One byte's worth of output characters, queued from front to back.
	typedef struct packed {
		char_t [GROUP_CHARS-1:0] chars;
		logic [IDX_W-1:0] last_idx;
		logic fin;
	} entry_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Map a six-bit value to its character in the standard alphabet.
	function automatic char_t sym(input logic [SIX_W-1:0] six);
		char_t s;
		char_t r;
		s = {1'b0, six};
		if (six < 6'd26) begin
			r = ASCII_UPPER_A + s;
		end else if (six < 6'd52) begin
			r = ASCII_LOWER_A + (s - 7'd26);
		end else if (six < 6'd62) begin
			r = ASCII_ZERO + (s - 7'd52);
		end else if (six == 6'd62) begin
			r = ASCII_PLUS;
		end else begin
			r = ASCII_SLASH;
		end
		return r;
	endfunction

endpackage

// ===== src/b64enc_if.sv =====
// Valid/ready channel interfaces for raw bytes and for encoded characters.
interface b64enc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64enc_char_if;
	logic valid;
	logic ready;
	logic [6:0] char_code;
	logic last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/b64enc_front.sv =====
// Front end: accepts raw bytes, tracks the group position and builds the characters of each byte.
module b64enc_front (
	input logic clk,
	input logic arst_n,
	b64enc_byte_if.sink raw,
	input b64enc_pkg::q_status_t q_status,
	output logic push,
	output b64enc_pkg::entry_t push_entry
);

	b64enc_pkg::pos_t pos_q;
	logic [b64enc_pkg::CARRY_W-1:0] carry_q;
	b64enc_pkg::pos_t pos_next;
	logic [b64enc_pkg::CARRY_W-1:0] carry_next;
	logic [7:0] b;
	logic fin;

	assign raw.ready = !q_status.full;
	assign push = raw.valid && raw.ready;
	assign b = raw.data_byte;
	assign fin = raw.final_byte;

	always_comb begin
		push_entry.chars = '{default: b64enc_pkg::PAD_CODE};
		push_entry.fin = fin;
		push_entry.last_idx = '0;
		pos_next = b64enc_pkg::POS_FIRST;
		carry_next = '0;
		unique case (pos_q)
			b64enc_pkg::POS_SECOND: begin
				push_entry.chars[0] = b64enc_pkg::sym({carry_q[1:0], b[7:4]});
				if (fin) begin
					push_entry.chars[1] = b64enc_pkg::sym({b[3:0], 2'b00});
					push_entry.last_idx = 2'd2;
				end else begin
					pos_next = b64enc_pkg::POS_THIRD;
					carry_next = b[3:0];
				end
			end
			b64enc_pkg::POS_THIRD: begin
				push_entry.chars[0] = b64enc_pkg::sym({carry_q, b[7:6]});
				push_entry.chars[1] = b64enc_pkg::sym(b[5:0]);
				push_entry.last_idx = 2'd1;
			end
			default: begin
				// The first position, and the unused code, which behaves the same.
				push_entry.chars[0] = b64enc_pkg::sym(b[7:2]);
				if (fin) begin
					push_entry.chars[1] = b64enc_pkg::sym({b[1:0], 4'b0000});
					push_entry.last_idx = 2'd3;
				end else begin
					pos_next = b64enc_pkg::POS_SECOND;
					carry_next = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= b64enc_pkg::POS_FIRST;
			carry_q <= '0;
		end else if (push) begin
			pos_q <= pos_next;
			carry_q <= carry_next;
		end
	end

endmodule

// ===== src/b64enc_fifo.sv =====
// Short register queue that decouples the byte front end from the character back end.
module b64enc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input b64enc_pkg::entry_t push_entry,
	input logic pop,
	output b64enc_pkg::entry_t head,
	output b64enc_pkg::q_status_t status
);

	b64enc_pkg::entry_t mem_q [b64enc_pkg::QDEPTH];
	logic [b64enc_pkg::PTR_W-1:0] wr_ptr_q;
	logic [b64enc_pkg::PTR_W-1:0] rd_ptr_q;
	logic [b64enc_pkg::CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full = (count_q == b64enc_pkg::CNT_W'(b64enc_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	function automatic logic [b64enc_pkg::PTR_W-1:0] ptr_inc(
		input logic [b64enc_pkg::PTR_W-1:0] p);
		logic [b64enc_pkg::PTR_W-1:0] r;
		if (p == b64enc_pkg::PTR_W'(b64enc_pkg::QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/b64enc_back.sv =====
// Back end: serializes queued characters into a registered output, one per cycle while the receiver is ready.
module b64enc_back (
	input logic clk,
	input logic arst_n,
	input b64enc_pkg::entry_t head,
	input b64enc_pkg::q_status_t q_status,
	output logic pop,
	b64enc_char_if.source encoded
);

	logic valid_q;
	b64enc_pkg::char_t char_q;
	logic last_q;
	logic [b64enc_pkg::IDX_W-1:0] idx_q;
	logic load;
	logic take;
	logic at_end;

	assign load = !valid_q || encoded.ready;
	assign take = load && !q_status.empty;
	assign at_end = (idx_q == head.last_idx);
	assign pop = take && at_end;

	assign encoded.valid = valid_q;
	assign encoded.char_code = char_q;
	assign encoded.last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= head.chars[idx_q];
			last_q <= head.fin && at_end;
		end
	end

endmodule

// ===== src/base64_stream_encoder_top.sv =====
// Top level of the Base64 stream encoder: front end, queue and character back end.
// An accepted word is written into the queue, then its first character goes into the output register.
// Throughput: one character per cycle while the receiver is ready, set by the back end's single
// output register; a byte yields one to four characters, and words are refused while the queue is full.
// Reset: arst_n clears the group position, carried bits, queue and output valid at once.
// After reset the encoder is at the start of a group, and its input is ready since the queue is empty.
module base64_stream_encoder_top (
	input logic clk,
	input logic arst_n,
	b64enc_byte_if.sink raw,
	b64enc_char_if.source encoded
);

	// Queue interface between the two halves. The front end pushes one entry per accepted
	// word holding all of that word's characters; the back end drains an entry one
	// character at a time and pops it when its last character is loaded.
	logic push;
	b64enc_pkg::entry_t push_entry;
	logic pop;
	b64enc_pkg::entry_t head;
	b64enc_pkg::q_status_t q_status;

	// The front end keeps the position within the three-byte group and the leftover
	// low bits of the previous byte, and is stalled only by a full queue.
	b64enc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw),
		.q_status(q_status),
		.push(push),
		.push_entry(push_entry)
	);

	b64enc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	// The back end owns the output register, so a waiting character never blocks the
	// front end from accepting further words while the queue has room.
	b64enc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.encoded(encoded)
	);

endmodule

// ===== src/b64enc_checker.sv =====
// Port-level checker for the Base64 stream encoder, bound to its top level.
module b64enc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [6:0] out_code,
	input logic out_last
);

	logic code_ok;

	assign code_ok = ((out_code >= 7'd65) && (out_code <= 7'd90)) ||
		((out_code >= 7'd97) && (out_code <= 7'd122)) ||
		((out_code >= 7'd48) && (out_code <= 7'd57)) ||
		(out_code == 7'd43) || (out_code == 7'd47) || (out_code == 7'd61);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code_ok)
		else $error("output character outside the Base64 alphabet");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_code) && $stable(out_last))
		else $error("output word changed while stalled");

endmodule

bind base64_stream_encoder_top b64enc_checker u_b64enc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(encoded.valid),
	.out_ready(encoded.ready),
	.out_code(encoded.char_code),
	.out_last(encoded.last_char)
);

// ===== verif/b64_char_checker.sv =====
// Checker that predicts the Base64 characters of each accepted byte word and compares the encoder output.
module b64_char_checker
	import b64enc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_ready,
	input logic [BYTE_W-1:0] data_byte,
	input logic final_byte,
	input logic char_valid,
	input logic char_ready,
	input char_t char_code,
	input logic last_char,
	output int unsigned error_count,
	output int unsigned chars_awaited
);

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		char_t code;
		logic last;
	} b64_char_t;

	b64_char_t awaited_chars[$];
	pos_t group_pos;
	logic [CARRY_W-1:0] carry;

	initial begin
		error_count = 0;
		chars_awaited = 0;
	end

	function automatic char_t b64_symbol(input logic [SIX_W-1:0] six);
		int idx;
		idx = 63 - int'(six);
		return char_t'(ALPHABET[8*idx +: 8]);
	endfunction

	task automatic await_char(input char_t code, input logic last);
		awaited_chars.push_back('{code: code, last: last});
	endtask

	// A group position that never occurs in practice falls into the first-byte branch.
	task automatic encode_word(input logic [BYTE_W-1:0] b, input logic fin);
		case (group_pos)
			POS_SECOND: begin
				await_char(b64_symbol({carry[1:0], b[7:4]}), 1'b0);
				if (fin) begin
					await_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
					await_char(PAD_CODE, 1'b1);
					group_pos = POS_FIRST;
					carry = '0;
				end else begin
					group_pos = POS_THIRD;
					carry = b[3:0];
				end
			end
			POS_THIRD: begin
				await_char(b64_symbol({carry, b[7:6]}), 1'b0);
				await_char(b64_symbol(b[5:0]), fin);
				group_pos = POS_FIRST;
				carry = '0;
			end
			default: begin
				await_char(b64_symbol(b[7:2]), 1'b0);
				if (fin) begin
					await_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
					await_char(PAD_CODE, 1'b0);
					await_char(PAD_CODE, 1'b1);
					group_pos = POS_FIRST;
					carry = '0;
				end else begin
					group_pos = POS_SECOND;
					carry = {2'b00, b[1:0]};
				end
			end
		endcase
	endtask

	// Output is checked before the new byte is predicted, since no character of the
	// same edge can stem from the byte taken at that edge.
	always @(posedge clk or negedge arst_n) begin
		b64_char_t want;
		if (!arst_n) begin
			group_pos = POS_FIRST;
			carry = '0;
			awaited_chars.delete();
			chars_awaited = 0;
		end else begin
			if (char_valid && char_ready) begin
				if (awaited_chars.size() == 0) begin
					error_count++;
					$display("%0t: unexpected char, expected none, actual code %h last %b",
						$time, char_code, last_char);
				end else begin
					want = awaited_chars.pop_front();
					if (char_code !== want.code) begin
						error_count++;
						$display("%0t: char_code expected %h actual %h",
							$time, want.code, char_code);
					end
					if (last_char !== want.last) begin
						error_count++;
						$display("%0t: last_char expected %b actual %b",
							$time, want.last, last_char);
					end
				end
			end
			if (byte_valid && byte_ready) begin
				encode_word(data_byte, final_byte);
			end
			chars_awaited = awaited_chars.size();
		end
	end

endmodule

// ===== verif/tb_base64_stream_encoder_top.sv =====
// Testbench top for the Base64 stream encoder: clock, reset, byte and character traffic, verdict.
module tb_base64_stream_encoder_top;
	import b64enc_pkg::*;

	// Roughly how many byte words the run sends in all.
	localparam int unsigned ITEM_TARGET = 400;
	// Longest random pause on either side, in cycles.
	localparam int unsigned MAX_GAP = 14;
	// The receiver stops taking characters this long so the encoder backs up.
	localparam int unsigned LONG_HOLD = 80;
	// Cycles without any handshake before the run is declared hung.
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	// Settling time after the last expected character.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned DIRECTED_WORDS = 25;

	logic clk;
	logic arst_n;
	int unsigned error_count;
	int unsigned chars_awaited;
	int unsigned words_sent;
	bit sender_quiet;

	b64enc_byte_if raw_bus();
	b64enc_char_if char_bus();

	base64_stream_encoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.raw(raw_bus),
		.encoded(char_bus)
	);

	b64_char_checker char_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(raw_bus.valid),
		.byte_ready(raw_bus.ready),
		.data_byte(raw_bus.data_byte),
		.final_byte(raw_bus.final_byte),
		.char_valid(char_bus.valid),
		.char_ready(char_bus.ready),
		.char_code(char_bus.char_code),
		.last_char(char_bus.last_char),
		.error_count(error_count),
		.chars_awaited(chars_awaited)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one byte word, after an optional pause, and hold it until it is taken.
	// The valid is only lowered when a pause is drawn, so back-to-back words never
	// see valid dropped and raised within one time step.
	task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int unsigned gap;
		gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			raw_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw_bus.valid <= 1'b1;
		raw_bus.data_byte <= b;
		raw_bus.final_byte <= fin;
		do @(posedge clk); while (!raw_bus.ready);
		words_sent++;
		@(negedge clk);
	endtask

	// Random byte with the all-zero and all-one patterns drawn more often than chance.
	function automatic logic [BYTE_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return 8'h00;
		end else if (r == 1) begin
			return 8'hFF;
		end
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Stimulus: reset, a directed set of short messages, then random messages.
	initial begin
		logic [BYTE_W:0] directed [DIRECTED_WORDS];
		int unsigned msg_len;
		int unsigned r;
		arst_n = 1'b0;
		raw_bus.valid = 1'b0;
		raw_bus.data_byte = '0;
		raw_bus.final_byte = 1'b0;
		char_bus.ready = 1'b0;
		words_sent = 0;
		sender_quiet = 1'b0;

		// Each entry is {final flag, byte}. The messages cover every length from one
		// to six bytes, so the flush happens at each group position: a lone byte gets
		// two pad characters, two bytes get one, and a full group gets none. The zero
		// and all-one bytes hit the first and last letters of the alphabet, and the
		// triple 0xFB 0xEF 0xBE produces nothing but plus signs.
		directed = '{
			{1'b1, 8'h00},
			{1'b1, 8'hFF},
			{1'b0, 8'hFF}, {1'b1, 8'hFE},
			{1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
			{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
			{1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b1, 8'h61},
			{1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03}, {1'b0, 8'h80}, {1'b1, 8'h7F},
			{1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'hAA},
			{1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b1, 8'h55}
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_WORDS; i++) begin
			offer_byte(directed[i][BYTE_W-1:0], directed[i][BYTE_W]);
		end

		// Random messages: mostly short ones, now and then a long one. Every fourth
		// message or so is sent without pauses to keep the encoder at full rate.
		while (words_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				msg_len = $urandom_range(1, 6);
			end else if (r < 9) begin
				msg_len = $urandom_range(7, 20);
			end else begin
				msg_len = $urandom_range(21, 48);
			end
			sender_quiet = ($urandom_range(0, 3) == 0);
			for (int unsigned k = 0; k < msg_len; k++) begin
				offer_byte(pick_byte(), k == msg_len - 1);
			end
		end
		raw_bus.valid <= 1'b0;

		// Wait for the outstanding characters, then give stray ones time to show up.
		while (chars_awaited != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0 && chars_awaited == 0) begin
			$display("tb_base64_stream_encoder_top: clean");
		end else begin
			$display("tb_base64_stream_encoder_top: errors");
		end
		$finish;
	end

	// Receiver: a random stall before each character, with stretches of none, and
	// twice a long hold so the queue fills and the encoder refuses input words.
	initial begin
		int unsigned stall;
		int unsigned taken;
		bit quiet;
		taken = 0;
		quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 32 == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
			end
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (taken == 100 || taken == 500) begin
				stall = LONG_HOLD;
			end
			if (stall != 0) begin
				char_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			char_bus.ready <= 1'b1;
			do @(posedge clk); while (!char_bus.valid);
			taken++;
			@(negedge clk);
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	initial begin
		int unsigned stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((raw_bus.valid && raw_bus.ready) || (char_bus.valid && char_bus.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("tb_base64_stream_encoder_top: errors");
		$finish;
	end

endmodule

// ===== base64_stream_encoder_top.f =====
src/b64enc_pkg.sv
src/b64enc_if.sv
src/b64enc_front.sv
src/b64enc_fifo.sv
src/b64enc_back.sv
src/base64_stream_encoder_top.sv
src/b64enc_checker.sv
verif/b64_char_checker.sv
verif/tb_base64_stream_encoder_top.sv
